// ===== design/nnueacc_pkg.sv =====
`timescale 1ns / 1ps

package nnueacc_pkg;

    // default accumulator elements per perspective
    localparam int ACC_SIZE_DEF = 1024;

    // field widths
    localparam int ACC_W     = 16;
    localparam int ELEM_W    = 10;
    localparam int ACTION_W  = 3;
    localparam int CEIL_W    = 15;
    localparam int SHIFT_W   = 4;
    localparam int ACT_OUT_W = 8;
    localparam int CFG_IDX_W = 1;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD_SUB = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PAIR    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_CEILING  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_SHIFT = 1'b1;

    // configuration reset values
    localparam logic [CEIL_W-1:0]  CLIP_CEILING_RST  = 15'd255;
    localparam logic [SHIFT_W-1:0] PRODUCT_SHIFT_RST = 4'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic                    perspective;
        logic [ELEM_W-1:0]       element;
        logic signed [ACC_W-1:0] add_weight;
        logic signed [ACC_W-1:0] sub_weight;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic [ACT_OUT_W-1:0] activation;
        logic                 final_res;
    } t_out_item;

    typedef struct packed {
        logic [CEIL_W-1:0]  clip_ceiling;
        logic [SHIFT_W-1:0] product_shift;
    } t_cfg;

endpackage

// ===== design/nnueacc_ram.sv =====
`timescale 1ns / 1ps

module nnueacc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read returns the old word on a collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/nnueacc_pair_act.sv =====
`timescale 1ns / 1ps

module nnueacc_pair_act (
    input  logic signed [nnueacc_pkg::ACC_W-1:0] i_first,
    input  logic signed [nnueacc_pkg::ACC_W-1:0] i_second,
    input  nnueacc_pkg::t_cfg                    i_cfg,
    output logic [nnueacc_pkg::ACT_OUT_W-1:0]    o_act
);

    logic signed [16:0] ceil_s;
    logic signed [16:0] first_s;
    logic signed [16:0] second_s;
    logic signed [16:0] clamp1;
    logic signed [16:0] clamp2;
    logic [15:0]        shifted_u;
    logic signed [15:0] shifted;
    logic signed [15:0] capped2;
    logic signed [31:0] prod;

    always_comb begin
        ceil_s   = signed'({2'b00, i_cfg.clip_ceiling});
        first_s  = 17'(i_first);
        second_s = 17'(i_second);

        // first value clamped to [0, ceiling]
        if (first_s < 17'sd0) begin
            clamp1 = 17'sd0;
        end else if (first_s > ceil_s) begin
            clamp1 = ceil_s;
        end else begin
            clamp1 = first_s;
        end

        // second value only capped at the ceiling
        if (second_s > ceil_s) begin
            clamp2 = ceil_s;
        end else begin
            clamp2 = second_s;
        end

        // shift and wrap to 16 bits
        shifted_u = clamp1[15:0] << i_cfg.product_shift;
        shifted   = signed'(shifted_u);
        capped2   = clamp2[15:0];
        prod      = shifted * capped2;

        // high half saturated to 0..255
        if (prod[31]) begin
            o_act = '0;
        end else if (|prod[30:24]) begin
            o_act = '1;
        end else begin
            o_act = prod[23:16];
        end
    end

endmodule

// ===== design/nnue_accumulator_pairwise_activation.sv =====
`timescale 1ns / 1ps

// Two perspectives of 16-bit accumulators with a pairwise clamped-product output.
// An item is taken in every clock cycle (busy stays low). Updates (load, add,
// subtract, add and subtract) wrap modulo 2^16 and give no result. An activate
// item goes through the read stage registers and the result register. The
// accumulator words are read at the transfer edge, and the clamp, multiply and
// saturation run in the following cycle ahead of the result register. Each
// perspective's elements sit in two single-port-read RAMs, the lower and the
// upper half, so that both words of a pair come out in one read; an update
// written in one cycle is forwarded to an item reading the same word in the next.
// The result strobe lasts one cycle and cannot be held off, so the receiver must
// take every result as it appears. Accumulator words hold no defined value until
// loaded.
module nnue_accumulator_pairwise_activation #(
    parameter int ACC_SIZE = nnueacc_pkg::ACC_SIZE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  nnueacc_pkg::t_in_item                  i_item,
    output logic                                   o_result_valid,
    output nnueacc_pkg::t_out_item                 o_result,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [nnueacc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnueacc_pkg::CEIL_W-1:0]         i_cfg_data
);

    localparam int HALF  = ACC_SIZE / 2;
    localparam int DEPTH = 2 * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = nnueacc_pkg::ACC_W;

    // configuration registers
    nnueacc_pkg::t_cfg r_cfg;

    // read stage
    logic                               r_s1_valid;
    logic [nnueacc_pkg::ACTION_W-1:0]   r_s1_action;
    logic                               r_s1_hi;
    logic                               r_s1_in_range;
    logic [AW-1:0]                      r_s1_addr;
    logic [DW-1:0]                      r_s1_addw;
    logic [DW-1:0]                      r_s1_subw;
    logic                               r_s1_last;

    // forwarding of the previous cycle's write
    logic          r_fwd_valid;
    logic          r_fwd_hi;
    logic [AW-1:0] r_fwd_addr;
    logic [DW-1:0] r_fwd_data;

    // result register
    logic                    r_out_valid;
    nnueacc_pkg::t_out_item  r_out;

    logic          accept;
    logic [31:0]   elem_w;
    logic [31:0]   idx_w;
    logic [31:0]   addr_w;
    logic          in_low;
    logic          n_in_range;
    logic [AW-1:0] n_addr;

    logic [DW-1:0] lo_rdata;
    logic [DW-1:0] hi_rdata;
    logic [DW-1:0] lo_word;
    logic [DW-1:0] hi_word;
    logic [DW-1:0] cur_word;
    logic [DW-1:0] new_word;
    logic          upd_we;
    logic          lo_we;
    logic          hi_we;
    logic [nnueacc_pkg::ACT_OUT_W-1:0] pair_act;

    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_ceiling  <= nnueacc_pkg::CLIP_CEILING_RST;
            r_cfg.product_shift <= nnueacc_pkg::PRODUCT_SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                nnueacc_pkg::CFG_CLIP_CEILING: begin
                    r_cfg.clip_ceiling <= i_cfg_data;
                end
                nnueacc_pkg::CFG_PRODUCT_SHIFT: begin
                    r_cfg.product_shift <= i_cfg_data[nnueacc_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // bank select and word address of the incoming item
    always_comb begin
        elem_w = 32'(i_item.element);
        in_low = elem_w < 32'(HALF);
        idx_w  = in_low ? elem_w : elem_w - 32'(HALF);
        addr_w = i_item.perspective ? idx_w + 32'(HALF) : idx_w;
        n_addr = addr_w[AW-1:0];
        if (i_item.action == nnueacc_pkg::ACT_PAIR) begin
            n_in_range = in_low;
        end else begin
            n_in_range = elem_w < 32'(ACC_SIZE);
        end
    end

    // read stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_action   <= i_item.action;
        r_s1_hi       <= !in_low;
        r_s1_in_range <= n_in_range;
        r_s1_addr     <= n_addr;
        r_s1_addw     <= i_item.add_weight;
        r_s1_subw     <= i_item.sub_weight;
        r_s1_last     <= i_item.last;
    end

    // lower and upper half of both perspectives
    nnueacc_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (lo_we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_word),
        .i_raddr (n_addr),
        .o_rdata (lo_rdata)
    );

    nnueacc_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (hi_we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_word),
        .i_raddr (n_addr),
        .o_rdata (hi_rdata)
    );

    // take the forwarded word of the previous write when the addresses collide
    always_comb begin
        lo_word = lo_rdata;
        hi_word = hi_rdata;
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            if (r_fwd_hi) begin
                hi_word = r_fwd_data;
            end else begin
                lo_word = r_fwd_data;
            end
        end
        cur_word = r_s1_hi ? hi_word : lo_word;
    end

    // read-modify-write of one word
    always_comb begin
        upd_we   = r_s1_valid && r_s1_in_range;
        new_word = cur_word;
        case (r_s1_action)
            nnueacc_pkg::ACT_LOAD: begin
                new_word = r_s1_addw;
            end
            nnueacc_pkg::ACT_ADD: begin
                new_word = cur_word + r_s1_addw;
            end
            nnueacc_pkg::ACT_SUB: begin
                new_word = cur_word - r_s1_subw;
            end
            nnueacc_pkg::ACT_ADD_SUB: begin
                new_word = cur_word + r_s1_addw - r_s1_subw;
            end
            default: begin
                upd_we = 1'b0;
            end
        endcase
        lo_we = upd_we && !r_s1_hi;
        hi_we = upd_we && r_s1_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= upd_we;
        end
        r_fwd_hi   <= r_s1_hi;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= new_word;
    end

    // clamped pairwise product
    nnueacc_pair_act u_pair_act (
        .i_first  (signed'(lo_word)),
        .i_second (signed'(hi_word)),
        .i_cfg    (r_cfg),
        .o_act    (pair_act)
    );

    // result register, one strobe per activate transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid && (r_s1_action == nnueacc_pkg::ACT_PAIR);
        end
        r_out.activation <= r_s1_in_range ? pair_act : '0;
        r_out.final_res  <= r_s1_last;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import nnueacc_pkg::*;

    localparam int ACC_SIZE = ACC_SIZE_DEF;
    localparam int HALF     = ACC_SIZE / 2;

    // actions the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    // perspective select
    localparam logic SIDE_US   = 1'b0;
    localparam logic SIDE_THEM = 1'b1;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int DRAIN_LIMIT   = 64;
    localparam int SETTLE_CYCLES = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_result_valid;
    t_out_item            o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CEIL_W-1:0]    i_cfg_data;

    // accumulator shadow and configuration shadow
    logic [ACC_W-1:0]   acc_bank [2][ACC_SIZE];
    bit                 elem_loaded [2][ACC_SIZE];
    bit                 pair_loaded [2][HALF];
    logic [ELEM_W:0]    loaded_elems[$];
    logic [ELEM_W-1:0]  loaded_pairs[$];
    logic [CEIL_W-1:0]  clip_ceil_now;
    logic [SHIFT_W-1:0] shift_now;

    t_out_item expected_activations[$];
    int        fail_count;
    int        burst_left;

    nnue_accumulator_pairwise_activation #(
        .ACC_SIZE(ACC_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // clamp both words of a pair, shift the first, keep the saturated high half
    function automatic logic [ACT_OUT_W-1:0] calc_pair_activation(
        input logic side, input int j);
        int quant;
        int a;
        int b;
        int c1;
        int c2;
        int prod;
        int hi;
        logic signed [ACC_W-1:0] shifted;
        quant = int'(clip_ceil_now);
        a = $signed(acc_bank[side][j]);
        b = $signed(acc_bank[side][j + HALF]);
        c1 = (a < 0) ? 0 : a;
        if (c1 > quant) c1 = quant;
        c2 = (b > quant) ? quant : b;
        shifted = 16'(c1 << shift_now);
        prod = shifted * c2;
        if (prod < 0) return '0;
        hi = prod >>> 16;
        return (hi > 255) ? 8'd255 : hi[ACT_OUT_W-1:0];
    endfunction

    // record a written word and the pairs that become readable
    function automatic void mark_loaded(input logic side, input int e);
        int j;
        if (!elem_loaded[side][e]) begin
            elem_loaded[side][e] = 1'b1;
            loaded_elems.push_back({side, ELEM_W'(e)});
        end
        j = e % HALF;
        if (elem_loaded[side][j] && elem_loaded[side][j + HALF] && !pair_loaded[side][j]) begin
            pair_loaded[side][j] = 1'b1;
            loaded_pairs.push_back({side, 9'(j)});
        end
    endfunction

    // update the shadow accumulators and queue the expected activation
    function automatic void track_accumulators(input t_in_item it);
        t_out_item res;
        logic      s;
        int        e;
        s = it.perspective;
        e = int'(it.element);
        case (it.action)
            ACT_PAIR: begin
                res.activation = (e < HALF) ? calc_pair_activation(s, e) : '0;
                res.final_res  = it.last;
                expected_activations.push_back(res);
            end
            ACT_LOAD: begin
                acc_bank[s][e] = it.add_weight;
                mark_loaded(s, e);
            end
            ACT_ADD:     acc_bank[s][e] = acc_bank[s][e] + it.add_weight;
            ACT_SUB:     acc_bank[s][e] = acc_bank[s][e] - it.sub_weight;
            ACT_ADD_SUB: acc_bank[s][e] = acc_bank[s][e] + it.add_weight - it.sub_weight;
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_item(
        input logic [ACTION_W-1:0] act, input logic side, input int e,
        input logic [ACC_W-1:0] addw, input logic [ACC_W-1:0] subw, input logic last_flag);
        t_in_item it;
        it.action      = act;
        it.perspective = side;
        it.element     = ELEM_W'(e);
        it.add_weight  = addw;
        it.sub_weight  = subw;
        it.last        = last_flag;
        return it;
    endfunction

    // values biased around the clamp window, plus corners
    function automatic logic [ACC_W-1:0] pick_value();
        int quant;
        int v;
        quant = int'(clip_ceil_now);
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = $urandom_range(0, quant + quant / 4 + 1);
            2: v = -int'($urandom_range(0, quant + 1));
            default: begin
                case ($urandom_range(0, 6))
                    0: v = 0;
                    1: v = 1;
                    2: v = quant;
                    3: v = quant + 1;
                    4: v = 32767;
                    5: v = -32768;
                    default: v = -1;
                endcase
            end
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // one item transfer, with a random gap or a burst before it
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 8);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        track_accumulators(it);
    endtask

    // hold off new items until every expected result is back
    task automatic drain_results();
        int waited;
        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (expected_activations.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_activations.size() != 0) begin
            $error("%0d expected activations never arrived", expected_activations.size());
            fail_count++;
            expected_activations.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CEIL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_CLIP_CEILING) clip_ceil_now = data;
        else shift_now = data[SHIFT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int ceil_val, input int shift_val);
        drain_results();
        write_reg(CFG_CLIP_CEILING, CEIL_W'(ceil_val));
        // upper data bits are don't-care for the shift register
        write_reg(CFG_PRODUCT_SHIFT, {11'($urandom_range(0, 2047)), SHIFT_W'(shift_val)});
    endtask

    // check each result strobe against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (expected_activations.size() == 0) begin
                $error("unexpected result: activation %0d final_res %0b",
                       o_result.activation, o_result.final_res);
                fail_count++;
            end else begin
                want = expected_activations.pop_front();
                if (o_result.activation !== want.activation) begin
                    $error("activation mismatch: expected %0d, actual %0d",
                           want.activation, o_result.activation);
                    fail_count++;
                end
                if (o_result.final_res !== want.final_res) begin
                    $error("final_res mismatch: expected %0b, actual %0b",
                           want.final_res, o_result.final_res);
                    fail_count++;
                end
            end
        end
    end

    // corners of the fields, wrapping updates, pair range, ignored actions
    task automatic test_directed_cases();
        send_item(make_item(ACT_LOAD, SIDE_US, 0, 16'sd32767, '0, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_US, HALF, 16'sd32767, '1, 1'b1));
        send_item(make_item(ACT_LOAD, SIDE_US, HALF - 1, 16'h8000, 16'h7fff, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_US, ACC_SIZE - 1, 16'h8000, 16'h8000, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_THEM, 1, 16'sd100, '0, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_THEM, HALF + 1, -16'sd5, '0, 1'b0));
        // add past the top, subtract past the bottom, then both at once
        send_item(make_item(ACT_LOAD, SIDE_THEM, 2, 16'sd32767, '0, 1'b0));
        send_item(make_item(ACT_ADD, SIDE_THEM, 2, 16'sd1, 16'h7fff, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_THEM, HALF + 2, 16'h8000, '0, 1'b0));
        send_item(make_item(ACT_SUB, SIDE_THEM, HALF + 2, 16'h7fff, 16'sd1, 1'b0));
        send_item(make_item(ACT_ADD_SUB, SIDE_THEM, 2, 16'sd200, 16'h8000, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_US, 0, '1, '1, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_US, HALF - 1, '0, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_THEM, 1, '0, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_THEM, 2, '0, '0, 1'b1));
        // pair index beyond the lower half still answers, with zero
        send_item(make_item(ACT_PAIR, SIDE_US, HALF, '0, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_THEM, ACC_SIZE - 1, '1, '1, 1'b1));
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
            send_item(make_item(ACTION_W'(a), 1'($urandom), $urandom_range(0, ACC_SIZE - 1),
                                16'($urandom), 16'($urandom), 1'($urandom)));
        end
    endtask

    // a zero ceiling clamps the first word to zero
    task automatic test_zero_ceiling();
        set_config(0, PRODUCT_SHIFT_RST);
        send_item(make_item(ACT_PAIR, SIDE_US, 0, '0, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_THEM, 2, '0, '0, 1'b1));
    endtask

    // widest ceiling with both shift extremes, and a ceiling of one
    task automatic test_config_extremes();
        set_config(32767, 15);
        send_item(make_item(ACT_PAIR, SIDE_US, 0, '0, '0, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_US, 3, 16'sd1, '0, 1'b0));
        send_item(make_item(ACT_LOAD, SIDE_US, HALF + 3, 16'sd32767, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_US, 3, '0, '0, 1'b1));
        set_config(1, 0);
        send_item(make_item(ACT_PAIR, SIDE_US, 0, '0, '0, 1'b0));
        send_item(make_item(ACT_PAIR, SIDE_US, 3, '0, '0, 1'b1));
        set_config(32767, 0);
        send_item(make_item(ACT_PAIR, SIDE_US, 0, '0, '0, 1'b1));
        send_item(make_item(ACT_PAIR, SIDE_THEM, 2, '0, '0, 1'b0));
    endtask

    // load a few pairs, touch loaded words, then sweep loaded pairs
    task automatic run_update_sweep(inout int sent);
        logic             side;
        int               j;
        int               n_act;
        logic [ELEM_W:0]  ekey;
        logic [ELEM_W-1:0] pkey;
        side = 1'($urandom);
        repeat ($urandom_range(1, 6)) begin
            j = $urandom_range(0, HALF - 1);
            if ($urandom_range(0, 1) == 0) begin
                send_item(make_item(ACT_LOAD, side, j, pick_value(), 16'($urandom), 1'($urandom)));
                send_item(make_item(ACT_LOAD, side, j + HALF, pick_value(), 16'($urandom),
                                    1'($urandom)));
            end else begin
                send_item(make_item(ACT_LOAD, side, j + HALF, pick_value(), 16'($urandom),
                                    1'($urandom)));
                send_item(make_item(ACT_LOAD, side, j, pick_value(), 16'($urandom), 1'($urandom)));
            end
            sent += 2;
        end
        repeat ($urandom_range(0, 4)) begin
            ekey = loaded_elems[$urandom_range(0, loaded_elems.size() - 1)];
            send_item(make_item(ACTION_W'($urandom_range(ACT_ADD, ACT_ADD_SUB)), ekey[ELEM_W],
                                int'(ekey[ELEM_W-1:0]), pick_value(), pick_value(), 1'($urandom)));
            sent++;
        end
        n_act = $urandom_range(1, 8);
        for (int i = 0; i < n_act; i++) begin
            pkey = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
            send_item(make_item(ACT_PAIR, pkey[ELEM_W-1], int'(pkey[ELEM_W-2:0]),
                                16'($urandom), 16'($urandom), i == n_act - 1));
            sent++;
        end
    endtask

    // single stray items between sweeps
    task automatic run_stray_item(inout int sent);
        logic [ELEM_W:0]   ekey;
        logic [ELEM_W-1:0] pkey;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            ekey = loaded_elems[$urandom_range(0, loaded_elems.size() - 1)];
            send_item(make_item(ACTION_W'($urandom_range(ACT_LOAD, ACT_ADD_SUB)), ekey[ELEM_W],
                                int'(ekey[ELEM_W-1:0]), pick_value(), pick_value(), 1'($urandom)));
            sent++;
        end else if (r < 70) begin
            pkey = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
            send_item(make_item(ACT_PAIR, pkey[ELEM_W-1], int'(pkey[ELEM_W-2:0]),
                                16'($urandom), 16'($urandom), 1'($urandom)));
            sent++;
        end else if (r < 85) begin
            send_item(make_item(ACT_PAIR, 1'($urandom), $urandom_range(HALF, ACC_SIZE - 1),
                                16'($urandom), 16'($urandom), 1'($urandom)));
            sent++;
        end else begin
            // ignored by the block, so not counted
            send_item(make_item(ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
                                1'($urandom), $urandom_range(0, ACC_SIZE - 1),
                                16'($urandom), 16'($urandom), 1'($urandom)));
        end
    endtask

    // random traffic under a fresh setting per phase
    task automatic test_random_sweeps();
        int sent;
        int ceil_val;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_config(CLIP_CEILING_RST, PRODUCT_SHIFT_RST);
                1: set_config(32767, 0);
                2: set_config(1, 15);
                default: begin
                    ceil_val = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                                           : $urandom_range(1, 1023);
                    set_config(ceil_val, $urandom_range(0, 15));
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 60) run_update_sweep(sent);
                else run_stray_item(sent);
            end
        end
    endtask

    // main sequence
    initial begin
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CLIP_CEILING;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        fail_count  = 0;
        burst_left  = 0;
        clip_ceil_now = CLIP_CEILING_RST;
        shift_now     = PRODUCT_SHIFT_RST;
        for (int s = 0; s < 2; s++) begin
            for (int e = 0; e < ACC_SIZE; e++) begin
                acc_bank[s][e]    = '0;
                elem_loaded[s][e] = 1'b0;
            end
            for (int j = 0; j < HALF; j++) pair_loaded[s][j] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_zero_ceiling();
        test_config_extremes();
        test_random_sweeps();
        drain_results();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/nnueacc_pkg.sv
design/nnueacc_ram.sv
design/nnueacc_pair_act.sv
design/nnue_accumulator_pairwise_activation.sv
sim/testbench.sv
